// ===== src/cring_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cring_pkg
// Types and codes shared by the closable ring channel modules.
// ---------------------------------------------------------------------------
package cring_pkg;

	localparam int DATA_W    = 32;
	localparam int FILL_W    = 5;
	localparam int CAP_W     = 5;
	localparam int CFG_IDX_W = 2;

	// Command kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;
	localparam logic [1:0] KIND_CLOSE = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BLOCK   = 2'd1;
	localparam logic [1:0] ST_CLOSED  = 2'd2;
	localparam logic [1:0] ST_DEFAULT = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_DEFAULT = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [DATA_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data_out;
		logic              data_valid;
		logic [FILL_W-1:0] fill_level;
		logic              is_closed;
	} result_t;

	// Control outcome of one command; data is the default or zero, and
	// data_valid selects the slot memory read data instead.
	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data;
		logic              data_valid;
		logic [FILL_W-1:0] fill;
		logic              closed;
	} ctl_res_t;

endpackage

// ===== src/cring_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cring_mem
// Slot storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cring_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [cring_pkg::DATA_W-1:0]  wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [cring_pkg::DATA_W-1:0]  rdata
);
	import cring_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/cring_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cring_ctrl
// Queue pointers, fill count, closed flag and configuration registers.
// Decides each command, drives the slot memory and registers the outcome.
// ---------------------------------------------------------------------------
module cring_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  cring_pkg::cmd_t                 cmd,
	input  logic                            cfg_we,
	input  logic [cring_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cring_pkg::DATA_W-1:0]    cfg_data,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [cring_pkg::DATA_W-1:0]    mem_wdata,
	output logic                            mem_re,
	output logic [AW-1:0]                   mem_raddr,
	output logic                            done_s1,
	output cring_pkg::ctl_res_t             res_s1
);
	import cring_pkg::*;

	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
	localparam int NW = ((AW > CAP_W) ? AW : CAP_W) + 1;

	logic [CAP_W-1:0]  cap_q;
	logic [DATA_W-1:0] def_q;
	logic              has_def_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     wr_idx_q;
	logic [FILL_W-1:0] fill_q;
	logic              closed_q;

	logic [CAP_W-1:0]  cap_lo;
	logic [CAP_W-1:0]  eff_cap;
	logic [NW-1:0]     rd_inc;
	logic [NW-1:0]     wr_inc;
	logic [AW-1:0]     rd_next;
	logic [AW-1:0]     wr_next;
	logic              wr_ok;
	logic              rd_ok;
	ctl_res_t          res_d;

	// Capacity zero acts as one; saturate at the slot count, at most 31.
	assign cap_lo  = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign eff_cap = (cap_lo > CAP_MAX_V) ? CAP_MAX_V : cap_lo;

	assign rd_inc  = NW'(rd_idx_q) + NW'(1);
	assign wr_inc  = NW'(wr_idx_q) + NW'(1);
	assign rd_next = (rd_inc >= NW'(eff_cap)) ? '0 : rd_inc[AW-1:0];
	assign wr_next = (wr_inc >= NW'(eff_cap)) ? '0 : wr_inc[AW-1:0];

	assign wr_ok = (cmd.kind == KIND_WRITE) && !closed_q && (fill_q < eff_cap);
	assign rd_ok = (cmd.kind == KIND_READ) && (fill_q != '0);

	assign mem_we    = accept && wr_ok;
	assign mem_waddr = wr_idx_q;
	assign mem_wdata = cmd.data_in;
	assign mem_re    = accept && rd_ok;
	assign mem_raddr = rd_idx_q;

	always_comb begin
		res_d            = '0;
		res_d.status     = ST_OK;
		res_d.fill       = fill_q;
		res_d.closed     = closed_q;
		unique case (cmd.kind)
			KIND_WRITE: begin
				if (closed_q) begin
					res_d.status = ST_CLOSED;
				end else if (!wr_ok) begin
					res_d.status = ST_BLOCK;
				end else begin
					res_d.fill = fill_q + FILL_W'(1);
				end
			end
			KIND_READ: begin
				if (rd_ok) begin
					res_d.data_valid = 1'b1;
					res_d.fill       = fill_q - FILL_W'(1);
				end else if (closed_q) begin
					if (has_def_q) begin
						res_d.status = ST_DEFAULT;
						res_d.data   = def_q;
					end else begin
						res_d.status = ST_CLOSED;
					end
				end else begin
					res_d.status = ST_BLOCK;
				end
			end
			KIND_FLUSH: begin
				res_d.fill = '0;
			end
			KIND_CLOSE: begin
				res_d.closed = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_W'(1);
			def_q     <= '0;
			has_def_q <= 1'b0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			fill_q    <= '0;
			closed_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAPACITY: begin
					// New capacity: drop the queue, keep the closed flag.
					cap_q    <= cfg_data[CAP_W-1:0];
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					fill_q   <= '0;
				end
				REG_DEFAULT_VAL: begin
					def_q <= cfg_data;
				end
				REG_HAS_DEFAULT: begin
					has_def_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			fill_q   <= res_d.fill;
			closed_q <= res_d.closed;
			if (wr_ok) begin
				wr_idx_q <= wr_next;
			end
			if (rd_ok) begin
				rd_idx_q <= rd_next;
			end
			if (cmd.kind == KIND_FLUSH) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

endmodule

// ===== src/closable_ring_channel_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// closable_ring_channel_top
// Bounded ring FIFO channel with write, read, flush and sticky close.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the command transfers at
//   a rising edge with start high and busy low. busy stays low, so one
//   command may transfer in every cycle.
//   Result channel: done is high for exactly one cycle, in the cycle after
//   the command transfer, with the outcome on result. The receiver cannot
//   stall; it must take the result in that cycle.
//   The result is registered, and read data comes from the registered read
//   port of the slot memory; throughput is one command per cycle. Pointer and
//   fill updates take effect at the transfer edge, so a read right after a
//   write to the same slot sees the new data.
//   Configuration: cfg_we, cfg_idx, cfg_data write one register per cycle
//   (0 capacity, 1 default value, 2 default enable); the user must write
//   only while idle, which the block does not enforce. Writing capacity
//   empties the queue and keeps the closed state. Reset: queue empty and
//   open, capacity 1, no default; slot contents are undefined until written.
// ---------------------------------------------------------------------------
module closable_ring_channel_top #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  cring_pkg::cmd_t                 cmd,
	input  logic                            cfg_we,
	input  logic [cring_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cring_pkg::DATA_W-1:0]    cfg_data,
	output logic                            done,
	output cring_pkg::result_t              result
);
	import cring_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	ctl_res_t          res_s1;

	// Every command is taken as it arrives, so there is no hold-off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	cring_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.done_s1  (done),
		.res_s1   (res_s1)
	);

	cring_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		result.status     = res_s1.status;
		result.data_out   = res_s1.data_valid ? mem_rdata : res_s1.data;
		result.data_valid = res_s1.data_valid;
		result.fill_level = res_s1.fill;
		result.is_closed  = res_s1.closed;
	end

endmodule

// ===== src/cring_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cring_chk
// Port-level checks on the closable ring channel, bound to the top level.
// ---------------------------------------------------------------------------
module cring_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input cring_pkg::cmd_t    cmd,
	input logic               done,
	input cring_pkg::result_t result
);
	import cring_pkg::*;

	// A result appears only for a command transferred in the previous cycle.
	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a preceding command transfer");

	// Dequeued data only comes with an ok status.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.data_valid) |-> (result.status == ST_OK))
		else $error("data_valid with a failing status");

	// A default can only be returned by a closed, empty channel.
	a_default_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DEFAULT) |-> (result.is_closed && result.fill_level == '0))
		else $error("default returned by an open or nonempty channel");

	// Close is sticky across back-to-back results.
	a_close_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && $past(result.is_closed)) |-> result.is_closed)
		else $error("closed state dropped");

	// A blocked write means the queue holds entries.
	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.kind) == KIND_WRITE && result.status == ST_BLOCK)
			|-> (result.fill_level != '0))
		else $error("write blocked on an empty queue");

endmodule

bind closable_ring_channel_top cring_chk u_chk (.*);
